// ===== sv/anc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and command codes for the anagram checker
// no dependencies

package anc_pkg;

  // command field of an input transaction
  typedef enum logic [1:0] {
    CMD_FIRST  = 2'd0,
    CMD_SECOND = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  // request from the front end to the bin update stage
  typedef struct packed {
    logic en;      // count one byte into its bin
    logic second;  // byte belongs to the second string
    logic clear;   // drop all bins and the nonzero count
  } anc_req_t;

endpackage

// ===== sv/anagram_checker.sv =====
`timescale 1ns / 1ps
// anagram checker top level: command decode, string lengths, result register
// depends on anc_pkg, anc_bin_ctl and anc_bin_mem
//
// usage
//   input channel (in_valid_i / in_ready_o) carries cmd_i and ch_i. cmd first
//   or second counts byte ch_i into its string, finish asks for the verdict.
//   output channel (out_valid_o / out_ready_i) carries one transaction per
//   finish: is_match_o, lengths_equal_o, overflow_o.
// timing
//   one input transaction per cycle is taken, bytes and finish alike. each
//   byte does a read-modify-write of its bin in the count memory (read,
//   then update and write back); the write of the previous cycle is
//   forwarded, so back-to-back bytes on one bin never wait.
//   the verdict sits in the result register in the cycle after the finish.
// stall
//   while a verdict waits and out_ready_i is low, in_ready_o is low; a
//   verdict taken in a cycle frees the register for a new transaction in
//   that same cycle.
// reset
//   rst_ni clears lengths, flags, the nonzero count and all bin valid marks,
//   no clearing pass is needed. a finish clears all but the output valid flag the same way.

module anagram_checker
  import anc_pkg::*;
#(
  parameter int unsigned MAX_LEN       = 4096,
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] ch_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_match_o,
  output logic       lengths_equal_o,
  output logic       overflow_o
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned BIN_W = LEN_W + 1;
  localparam int unsigned CNT_W = $clog2(ALPHABET_SIZE + 1);
  localparam int unsigned IDX_W = $clog2(ALPHABET_SIZE);
  localparam logic [8:0]       ALPHA_LIM = 9'(ALPHABET_SIZE);
  localparam logic [LEN_W-1:0] LEN_LIM   = LEN_W'(MAX_LEN);

  logic             in_fire;
  cmd_e             cmd;
  logic             in_alpha;
  logic [LEN_W-1:0] len1_q, len1_d, len2_q, len2_d;
  logic             ovf_q, ovf_d;
  logic             out_vld_q, out_vld_d;
  logic             match_q, match_d, eq_q, eq_d, ovf_out_q, ovf_out_d;
  logic             fin_go;
  logic             all_zero;
  anc_req_t         req;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [BIN_W-1:0] rd_data, wr_data;

  // result register parts the two channels
  assign in_ready_o = !out_vld_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(cmd_i);
  assign in_alpha   = ({1'b0, ch_i} < ALPHA_LIM);

  // command decode, length tracking and overflow
  always_comb begin
    len1_d     = len1_q;
    len2_d     = len2_q;
    ovf_d      = ovf_q;
    req.en     = 1'b0;
    req.second = 1'b0;
    req.clear  = 1'b0;
    fin_go     = 1'b0;
    if (in_fire) begin
      case (cmd)
        CMD_FIRST: begin
          if (in_alpha) begin
            if (len1_q >= LEN_LIM) begin
              ovf_d = 1'b1;
            end else begin
              len1_d = len1_q + LEN_W'(1);
              req.en = 1'b1;
            end
          end
        end
        CMD_SECOND: begin
          req.second = 1'b1;
          if (in_alpha) begin
            if (len2_q >= LEN_LIM) begin
              ovf_d = 1'b1;
            end else begin
              len2_d = len2_q + LEN_W'(1);
              req.en = 1'b1;
            end
          end
        end
        CMD_FINISH: begin
          fin_go    = 1'b1;
          req.clear = 1'b1;
          len1_d    = '0;
          len2_d    = '0;
          ovf_d     = 1'b0;
        end
        default: begin
          // unused command code, no effect
        end
      endcase
    end
  end

  // verdict uses the nonzero count including the byte still in flight
  always_comb begin
    eq_d      = (len1_q == len2_q);
    ovf_out_d = ovf_q;
    match_d   = eq_d && all_zero && !ovf_q;
    if (fin_go) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len1_q    <= '0;
      len2_q    <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      len1_q    <= len1_d;
      len2_q    <= len2_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  // result payload, loaded only by a finish
  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      match_q   <= match_d;
      eq_q      <= eq_d;
      ovf_out_q <= ovf_out_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign is_match_o      = match_q;
  assign lengths_equal_o = eq_q;
  assign overflow_o      = ovf_out_q;

  anc_bin_ctl #(
    .DEPTH (ALPHABET_SIZE),
    .IDX_W (IDX_W),
    .BIN_W (BIN_W),
    .CNT_W (CNT_W)
  ) u_bin_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .addr_i     (ch_i[IDX_W-1:0]),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .all_zero_o (all_zero)
  );

  anc_bin_mem #(
    .DEPTH (ALPHABET_SIZE),
    .IDX_W (IDX_W),
    .BIN_W (BIN_W)
  ) u_bin_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // a finish transaction always produces a verdict on the next cycle
  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_o)
    else $error("finish without result");

  // a match needs equal lengths and no overflow
  a_match_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_match_o) |-> (lengths_equal_o && !overflow_o))
    else $error("inconsistent verdict");

  // held lengths never pass the limit
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len1_q <= LEN_LIM) && (len2_q <= LEN_LIM))
    else $error("string length beyond limit");

  // a byte of a full first string raises the overflow flag
  a_ovf_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd == CMD_FIRST) && in_alpha && (len1_q == LEN_LIM)) |=> ovf_q)
    else $error("overflow not flagged");

endmodule

// ===== sv/anc_bin_mem.sv =====
`timescale 1ns / 1ps
// difference count memory: one write port, one read port, registered read data
// no dependencies

module anc_bin_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = 8,
  parameter int unsigned BIN_W = 14
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [BIN_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [BIN_W-1:0] wr_data_i
);

  logic [BIN_W-1:0] mem_q [DEPTH];
  logic [BIN_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/anc_bin_ctl.sv =====
`timescale 1ns / 1ps
// bin read-modify-write stage: valid marks, write forwarding, nonzero bin count
// depends on anc_pkg; drives the ports of anc_bin_mem

module anc_bin_ctl
  import anc_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = 8,
  parameter int unsigned BIN_W = 14,
  parameter int unsigned CNT_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  anc_req_t         req_i,
  input  logic [IDX_W-1:0] addr_i,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_addr_o,
  input  logic [BIN_W-1:0] rd_data_i,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_addr_o,
  output logic [BIN_W-1:0] wr_data_o,
  output logic             all_zero_o
);

  logic             s1_vld_q, s1_vld_d;
  logic             s1_second_q;
  logic [IDX_W-1:0] s1_addr_q;
  logic             lw_vld_q, lw_vld_d;
  logic [IDX_W-1:0] lw_addr_q;
  logic [BIN_W-1:0] lw_data_q;
  logic [DEPTH-1:0] valid_q, valid_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic [BIN_W-1:0] cur_val, before_val, after_val;
  logic             fwd_hit;

  assign rd_en_o   = req_i.en;
  assign rd_addr_o = addr_i;

  // the write of the previous cycle is not yet visible in the read data
  assign fwd_hit    = lw_vld_q && (lw_addr_q == s1_addr_q);
  assign cur_val    = fwd_hit ? lw_data_q : rd_data_i;
  assign before_val = valid_q[s1_addr_q] ? cur_val : '0;
  assign after_val  = s1_second_q ? (before_val - BIN_W'(1)) : (before_val + BIN_W'(1));

  assign wr_en_o   = s1_vld_q;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = after_val;

  always_comb begin
    cnt_next = cnt_q;
    if (s1_vld_q) begin
      if (before_val == '0) begin
        cnt_next = cnt_q + CNT_W'(1);
      end else if (after_val == '0) begin
        cnt_next = cnt_q - CNT_W'(1);
      end
    end
  end

  assign all_zero_o = (cnt_next == '0);

  always_comb begin
    s1_vld_d = req_i.en;
    lw_vld_d = s1_vld_q;
    cnt_d    = req_i.clear ? '0 : cnt_next;
    valid_d  = valid_q;
    if (s1_vld_q) begin
      valid_d[s1_addr_q] = 1'b1;
    end
    if (req_i.clear) begin
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      lw_vld_q <= 1'b0;
      cnt_q    <= '0;
      valid_q  <= '0;
    end else begin
      s1_vld_q <= s1_vld_d;
      lw_vld_q <= lw_vld_d;
      cnt_q    <= cnt_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_second_q <= req_i.second;
    s1_addr_q   <= addr_i;
    lw_addr_q   <= s1_addr_q;
    lw_data_q   <= after_val;
  end

  // a nonzero count can only exist with some bin marked valid
  a_cnt_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (valid_q != '0))
    else $error("nonzero bin count with no valid bin");

  // clear empties the count and all marks on the next cycle
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clear |=> ((cnt_q == '0) && (valid_q == '0)))
    else $error("clear did not empty the bins");

  // a counted byte leaves its bin marked valid unless a clear comes in the same cycle
  a_mark_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !req_i.clear) |=> valid_q[$past(s1_addr_q)])
    else $error("updated bin not marked valid");

endmodule
